>>> hdl/kdeq_pkg.sv
// kdeq_pkg: shared constants and types of the key debounce event queue
// no dependencies
package kdeq_pkg;

   localparam int PORT_KEYS = 12;
   localparam int KEY_W     = 4;
   localparam int CNT_W     = 8;
   localparam int EVT_W     = 5;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd20;

   // register index, taken from the word address
   localparam logic REG_DEBOUNCE = 1'b0;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef struct packed {
      logic             pressed;
      logic [KEY_W-1:0] key;
   } evt_type;

endpackage

>>> hdl/kdeq_if.sv
// kdeq_req_if, kdeq_rsp_if: valid/ready channels of the key debounce event queue
// no dependencies
interface kdeq_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [11:0] pin_levels;

   modport source (output valid, kind, pin_levels, input ready);
   modport sink (input valid, kind, pin_levels, output ready);
endinterface

interface kdeq_rsp_if;
   logic        valid;
   logic        ready;
   logic        event_valid;
   logic [3:0]  event_key;
   logic        event_pressed;
   logic [11:0] stable_keys;

   modport source (output valid, event_valid, event_key, event_pressed, stable_keys,
                   input ready);
   modport sink (input valid, event_valid, event_key, event_pressed, stable_keys,
                 output ready);
endinterface

>>> hdl/kdeq_ram.sv
// kdeq_ram: generic single write port ram with registered read
// no dependencies
module kdeq_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/kdeq_csr.sv
// kdeq_csr: apb register file holding the debounce limit
// depends on kdeq_pkg
module kdeq_csr import kdeq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output logic [CNT_W-1:0]  debounce_ticks
);

   logic [CNT_W-1:0] ticks_ff;
   logic [CNT_W-1:0] ticks_in;
   logic             wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && pready;

   always_comb begin
      ticks_in = ticks_ff;
      if (wr_hit) begin
         unique case (paddr[ADDR_W-1])
            REG_DEBOUNCE: ticks_in = pwdata[CNT_W-1:0];
            default:      ticks_in = ticks_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= DEBOUNCE_RESET;
      end else begin
         ticks_ff <= ticks_in;
      end
   end

   always_comb begin
      unique case (paddr[ADDR_W-1])
         REG_DEBOUNCE: prdata = {{(DATA_W-CNT_W){1'b0}}, ticks_ff};
         default:      prdata = '0;
      endcase
   end

   assign debounce_ticks = ticks_ff;

endmodule

>>> hdl/key_debounce_event_queue.sv
// key_debounce_event_queue: whole-port key debouncer with an event ring
// depends on kdeq_pkg, kdeq_if, kdeq_ram, kdeq_csr
//
//   port    dir     kind       transfer
//   req     in      valid/rdy  kind, pin_levels
//   rsp     out     valid/rdy  event_valid, event_key, event_pressed, stable_keys
//   csr_*   in/out  apb        debounce_ticks at word 0
//
// a tick is answered from idle, or after a key scan when the stable state
// changes: the sequencer steps one key per cycle through the change mask
// a pop of a filled ring passes through ST_POP for the registered ram read;
// a pop of an empty ring is answered from idle with no event
// one item at a time; req is held off until the result has been transferred
// synchronous reset clears counters, stable state and ring pointers
module key_debounce_event_queue import kdeq_pkg::*; #(
   parameter int NUM_KEYS   = 12,
   parameter int RING_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   kdeq_req_if.sink          req,
   kdeq_rsp_if.source        rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int NK = (NUM_KEYS < PORT_KEYS) ? NUM_KEYS : PORT_KEYS;
   localparam int KM = (1 << NK) - 1;
   localparam logic [PORT_KEYS-1:0] KEYS_MASK = PORT_KEYS'(KM);
   localparam logic [KEY_W-1:0]     LAST_KEY  = KEY_W'(NK - 1);
   localparam int AW = $clog2(RING_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_POP  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [PORT_KEYS-1:0] last_ff, last_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [PORT_KEYS-1:0] stable_ff, stable_in;
   logic [PORT_KEYS-1:0] changed_ff, changed_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [AW-1:0]        tail_ff, tail_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 evt_valid_ff, evt_valid_in;
   evt_type              evt_ff, evt_in;
   logic [PORT_KEYS-1:0] rsp_stable_ff, rsp_stable_in;

   logic [CNT_W-1:0]     debounce_ticks;
   logic [PORT_KEYS-1:0] sample;
   logic [CNT_W-1:0]     count_inc;
   logic [AW-1:0]        head_next;
   logic [AW-1:0]        tail_next;
   logic                 take;
   logic                 ring_full;
   logic                 wr_en;
   evt_type              wr_evt;
   logic [EVT_W-1:0]     rd_data;
   evt_type              rd_evt;

   kdeq_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (csr_psel),
      .penable        (csr_penable),
      .pwrite         (csr_pwrite),
      .paddr          (csr_paddr),
      .pwdata         (csr_pwdata),
      .prdata         (csr_prdata),
      .pready         (csr_pready),
      .debounce_ticks (debounce_ticks)
   );

   kdeq_ram #(
      .WIDTH (EVT_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (head_ff),
      .wr_data (wr_evt),
      .rd_addr (tail_ff),
      .rd_data (rd_data)
   );

   assign rd_evt    = evt_type'(rd_data);
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign take      = req.valid && req.ready;
   assign sample    = ~req.pin_levels & KEYS_MASK;
   assign count_inc = count_ff + 1'b1;
   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
   assign ring_full = head_next == tail_ff;
   assign wr_en     = (state_ff == ST_SCAN) && changed_ff[key_ff] && !ring_full;
   assign wr_evt.pressed = stable_ff[key_ff];
   assign wr_evt.key     = key_ff;

   always_comb begin
      state_in      = state_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      stable_in     = stable_ff;
      changed_in    = changed_ff;
      key_in        = key_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      evt_valid_in  = evt_valid_ff;
      evt_in        = evt_ff;
      rsp_stable_in = rsp_stable_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               evt_valid_in  = 1'b0;
               evt_in        = '0;
               rsp_stable_in = stable_ff;
               rsp_valid_in  = 1'b1;
               if (req.kind == KIND_TICK) begin
                  if (sample != last_ff) begin
                     last_in  = sample;
                     count_in = '0;
                  end else if (count_ff < debounce_ticks) begin
                     count_in = count_inc;
                     if (count_inc == debounce_ticks && sample != stable_ff) begin
                        changed_in    = sample ^ stable_ff;
                        stable_in     = sample;
                        key_in        = '0;
                        rsp_valid_in  = 1'b0;
                        state_in      = ST_SCAN;
                     end
                  end
               end else if (head_ff != tail_ff) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_POP;
               end
            end
         end
         ST_SCAN: begin
            if (wr_en) begin
               head_in = head_next;
            end
            key_in = key_ff + 1'b1;
            if (key_ff == LAST_KEY) begin
               rsp_stable_in = stable_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_POP: begin
            evt_valid_in = 1'b1;
            evt_in       = rd_evt;
            tail_in      = tail_next;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= '0;
         count_ff     <= '0;
         stable_ff    <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         count_ff     <= count_in;
         stable_ff    <= stable_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      changed_ff    <= changed_in;
      key_ff        <= key_in;
      evt_valid_ff  <= evt_valid_in;
      evt_ff        <= evt_in;
      rsp_stable_ff <= rsp_stable_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.event_valid   = evt_valid_ff;
   assign rsp.event_key     = evt_ff.key;
   assign rsp.event_pressed = evt_ff.pressed;
   assign rsp.stable_keys   = rsp_stable_ff;

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> head_ff != tail_ff)
      else $error("ring write made the ring look empty");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (take && req.kind == KIND_POP && head_ff != tail_ff) |=> state_ff == ST_POP)
      else $error("pop of a filled ring did not read the ring");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !rsp_valid_ff)
      else $error("result offered while an item is still in work");

   a_stable_on_take: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(stable_ff))
      else $error("stable state changed without an accepted tick");

   a_scan_no_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |=> $stable(tail_ff))
      else $error("ring tail moved during a key scan");

endmodule
